[hdl/blt_pkg.sv]
// ---------------------------------------------------------------------------
// Basic line tokenizer package
// Shared result and bundle types, token kind codes and character constants.
// ---------------------------------------------------------------------------
package blt_pkg;

   // Most results that one input item can cause.
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   // Depth of the bundle queue between front and back ends.
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

   // Token kind codes.
   localparam logic [4:0] KIND_END       = 5'd0;
   localparam logic [4:0] KIND_IDENT     = 5'd1;
   localparam logic [4:0] KIND_NUMBER    = 5'd2;
   localparam logic [4:0] KIND_STRING    = 5'd3;
   localparam logic [4:0] KIND_PLUS      = 5'd4;
   localparam logic [4:0] KIND_MINUS     = 5'd5;
   localparam logic [4:0] KIND_STAR      = 5'd6;
   localparam logic [4:0] KIND_SLASH     = 5'd7;
   localparam logic [4:0] KIND_LPAREN    = 5'd8;
   localparam logic [4:0] KIND_RPAREN    = 5'd9;
   localparam logic [4:0] KIND_EQUAL     = 5'd10;
   localparam logic [4:0] KIND_LESS      = 5'd11;
   localparam logic [4:0] KIND_GREATER   = 5'd12;
   localparam logic [4:0] KIND_LESS_EQ   = 5'd13;
   localparam logic [4:0] KIND_GREATER_EQ = 5'd14;
   localparam logic [4:0] KIND_NOT_EQUAL = 5'd15;
   localparam logic [4:0] KIND_COLON     = 5'd16;

   // Error codes.
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED  = 2'd1;
   localparam logic [1:0] ERR_UNTERM_STR  = 2'd2;

   // Character constants.
   localparam logic [7:0] CHR_APOS      = 8'h27;
   localparam logic [7:0] CHR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHR_DOLLAR    = 8'h24;
   localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHR_LF        = 8'h0A;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_PLUS      = 8'h2B;
   localparam logic [7:0] CHR_MINUS     = 8'h2D;
   localparam logic [7:0] CHR_STAR      = 8'h2A;
   localparam logic [7:0] CHR_SLASH     = 8'h2F;
   localparam logic [7:0] CHR_LPAREN    = 8'h28;
   localparam logic [7:0] CHR_RPAREN    = 8'h29;
   localparam logic [7:0] CHR_EQUAL     = 8'h3D;
   localparam logic [7:0] CHR_COLON     = 8'h3A;
   localparam logic [7:0] CHR_LESS      = 8'h3C;
   localparam logic [7:0] CHR_GREATER   = 8'h3E;

   // One result item.
   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] text_char;
      logic       char_valid;
      logic       token_done;
      logic [1:0] error;
      logic       last;
   } result_type;

   // All results caused by one input item.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [COUNT_W-1:0]           count;
   } bundle_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

[hdl/blt_if.sv]
// ---------------------------------------------------------------------------
// Basic line tokenizer channels
// Valid/ready channels for source characters and token results.
// ---------------------------------------------------------------------------
interface blt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       has_char;
   logic       line_end;

   modport source (output valid, ch, has_char, line_end, input ready);
   modport sink   (input valid, ch, has_char, line_end, output ready);
endinterface

interface blt_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] kind;
   logic [7:0] text_char;
   logic       char_valid;
   logic       token_done;
   logic [1:0] error;
   logic       last;

   modport source (output valid, kind, text_char, char_valid, token_done, error, last,
                   input ready);
   modport sink   (input valid, kind, text_char, char_valid, token_done, error, last,
                   output ready);
endinterface

[hdl/blt_front.sv]
// ---------------------------------------------------------------------------
// Basic line tokenizer front end
// Accepts one character item per cycle while the queue is not full, runs the
// lexer state and builds the bundle of results that the item causes.
// ---------------------------------------------------------------------------
module blt_front (
   input  logic                    clock,
   input  logic                    reset,
   blt_req_if.sink                 req_link,
   input  blt_pkg::queue_stat_type q_stat,
   output logic                    push,
   output blt_pkg::bundle_type     push_bundle
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_LESS,
      MODE_GREATER,
      MODE_DISCARD
   } lex_mode_type;

   lex_mode_type        mode_ff;
   lex_mode_type        mode_in;
   blt_pkg::bundle_type bundle;
   logic                xfer;

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A]}) ? (c - 8'h20) : c;
   endfunction

   // Appends one result to a bundle.
   function automatic blt_pkg::bundle_type put_res(
      input blt_pkg::bundle_type b,
      input logic [4:0]          kind,
      input logic [7:0]          chr,
      input logic                valid,
      input logic                done,
      input logic [1:0]          err
   );
      blt_pkg::bundle_type r;
      r = b;
      if (b.count < blt_pkg::COUNT_W'(blt_pkg::MAX_RESULTS)) begin
         r.slot[b.count[blt_pkg::SLOT_W-1:0]] = '{kind, chr, valid, done, err, 1'b0};
         r.count = b.count + 1'b1;
      end
      return r;
   endfunction

   assign req_link.ready = !q_stat.full;
   assign xfer           = req_link.valid && req_link.ready;

   // Lexer step: feed the character, then close the line if asked.
   always_comb begin
      logic [7:0] c;
      logic       restart;
      c       = req_link.ch;
      restart = 1'b0;
      mode_in = mode_ff;
      bundle  = '0;

      if (req_link.has_char) begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == blt_pkg::CHR_UNDERSCORE ||
                   c == blt_pkg::CHR_DOLLAR) begin
                  bundle = put_res(bundle, blt_pkg::KIND_IDENT, to_upper(c), 1'b1, 1'b0,
                                   blt_pkg::ERR_NONE);
               end else begin
                  bundle  = put_res(bundle, blt_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1,
                                    blt_pkg::ERR_NONE);
                  restart = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c)) begin
                  bundle = put_res(bundle, blt_pkg::KIND_NUMBER, c, 1'b1, 1'b0,
                                   blt_pkg::ERR_NONE);
               end else begin
                  bundle  = put_res(bundle, blt_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1,
                                    blt_pkg::ERR_NONE);
                  restart = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == blt_pkg::CHR_DQUOTE) begin
                  bundle  = put_res(bundle, blt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
                                    blt_pkg::ERR_NONE);
                  mode_in = MODE_IDLE;
               end else if (c == blt_pkg::CHR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  bundle = put_res(bundle, blt_pkg::KIND_STRING, c, 1'b1, 1'b0,
                                   blt_pkg::ERR_NONE);
               end
            end
            MODE_ESCAPE: begin
               bundle  = put_res(bundle, blt_pkg::KIND_STRING,
                                 (c == blt_pkg::CHR_LOWER_N) ? blt_pkg::CHR_LF :
                                 (c == blt_pkg::CHR_LOWER_T) ? blt_pkg::CHR_TAB : c,
                                 1'b1, 1'b0, blt_pkg::ERR_NONE);
               mode_in = MODE_STRING;
            end
            MODE_LESS: begin
               mode_in = MODE_IDLE;
               if (c == blt_pkg::CHR_EQUAL) begin
                  bundle = put_res(bundle, blt_pkg::KIND_LESS_EQ, 8'h00, 1'b0, 1'b1,
                                   blt_pkg::ERR_NONE);
               end else if (c == blt_pkg::CHR_GREATER) begin
                  bundle = put_res(bundle, blt_pkg::KIND_NOT_EQUAL, 8'h00, 1'b0, 1'b1,
                                   blt_pkg::ERR_NONE);
               end else begin
                  bundle  = put_res(bundle, blt_pkg::KIND_LESS, 8'h00, 1'b0, 1'b1,
                                    blt_pkg::ERR_NONE);
                  restart = 1'b1;
               end
            end
            MODE_GREATER: begin
               mode_in = MODE_IDLE;
               if (c == blt_pkg::CHR_EQUAL) begin
                  bundle = put_res(bundle, blt_pkg::KIND_GREATER_EQ, 8'h00, 1'b0, 1'b1,
                                   blt_pkg::ERR_NONE);
               end else begin
                  bundle  = put_res(bundle, blt_pkg::KIND_GREATER, 8'h00, 1'b0, 1'b1,
                                    blt_pkg::ERR_NONE);
                  restart = 1'b1;
               end
            end
            MODE_DISCARD: begin
               mode_in = MODE_DISCARD;
            end
            default: begin
               restart = 1'b1;
            end
         endcase

         // Start of a new token.
         if (restart) begin
            mode_in = MODE_IDLE;
            if (is_space(c)) begin
               mode_in = MODE_IDLE;
            end else if (c == blt_pkg::CHR_APOS) begin
               mode_in = MODE_DISCARD;
            end else if (is_alpha(c) || c == blt_pkg::CHR_UNDERSCORE) begin
               bundle  = put_res(bundle, blt_pkg::KIND_IDENT, to_upper(c), 1'b1, 1'b0,
                                 blt_pkg::ERR_NONE);
               mode_in = MODE_IDENT;
            end else if (is_digit(c)) begin
               bundle  = put_res(bundle, blt_pkg::KIND_NUMBER, c, 1'b1, 1'b0,
                                 blt_pkg::ERR_NONE);
               mode_in = MODE_NUMBER;
            end else begin
               case (c)
                  blt_pkg::CHR_DQUOTE:  mode_in = MODE_STRING;
                  blt_pkg::CHR_LESS:    mode_in = MODE_LESS;
                  blt_pkg::CHR_GREATER: mode_in = MODE_GREATER;
                  blt_pkg::CHR_PLUS: begin
                     bundle = put_res(bundle, blt_pkg::KIND_PLUS, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  blt_pkg::CHR_MINUS: begin
                     bundle = put_res(bundle, blt_pkg::KIND_MINUS, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  blt_pkg::CHR_STAR: begin
                     bundle = put_res(bundle, blt_pkg::KIND_STAR, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  blt_pkg::CHR_SLASH: begin
                     bundle = put_res(bundle, blt_pkg::KIND_SLASH, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  blt_pkg::CHR_LPAREN: begin
                     bundle = put_res(bundle, blt_pkg::KIND_LPAREN, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  blt_pkg::CHR_RPAREN: begin
                     bundle = put_res(bundle, blt_pkg::KIND_RPAREN, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  blt_pkg::CHR_EQUAL: begin
                     bundle = put_res(bundle, blt_pkg::KIND_EQUAL, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  blt_pkg::CHR_COLON: begin
                     bundle = put_res(bundle, blt_pkg::KIND_COLON, 8'h00, 1'b0, 1'b1,
                                      blt_pkg::ERR_NONE);
                  end
                  default: begin
                     bundle  = put_res(bundle, blt_pkg::KIND_END, 8'h00, 1'b0, 1'b0,
                                       blt_pkg::ERR_UNEXPECTED);
                     mode_in = MODE_DISCARD;
                  end
               endcase
            end
         end
      end

      // Line end closes open tokens, flags an open string and emits End.
      if (req_link.line_end) begin
         case (mode_in)
            MODE_IDENT: begin
               bundle = put_res(bundle, blt_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1,
                                blt_pkg::ERR_NONE);
            end
            MODE_NUMBER: begin
               bundle = put_res(bundle, blt_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1,
                                blt_pkg::ERR_NONE);
            end
            MODE_LESS: begin
               bundle = put_res(bundle, blt_pkg::KIND_LESS, 8'h00, 1'b0, 1'b1,
                                blt_pkg::ERR_NONE);
            end
            MODE_GREATER: begin
               bundle = put_res(bundle, blt_pkg::KIND_GREATER, 8'h00, 1'b0, 1'b1,
                                blt_pkg::ERR_NONE);
            end
            MODE_ESCAPE: begin
               bundle = put_res(bundle, blt_pkg::KIND_STRING, blt_pkg::CHR_BACKSLASH, 1'b1,
                                1'b0, blt_pkg::ERR_NONE);
               bundle = put_res(bundle, blt_pkg::KIND_END, 8'h00, 1'b0, 1'b0,
                                blt_pkg::ERR_UNTERM_STR);
            end
            MODE_STRING: begin
               bundle = put_res(bundle, blt_pkg::KIND_END, 8'h00, 1'b0, 1'b0,
                                blt_pkg::ERR_UNTERM_STR);
            end
            default: begin
            end
         endcase
         bundle  = put_res(bundle, blt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, blt_pkg::ERR_NONE);
         mode_in = MODE_IDLE;
      end

      // Mark the final result of this item.
      if (bundle.count != '0) begin
         bundle.slot[blt_pkg::SLOT_W'(bundle.count - 1'b1)].last = 1'b1;
      end
   end

   assign push        = xfer && (bundle.count != '0);
   assign push_bundle = bundle;

   // Lexer mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (xfer) begin
         mode_ff <= mode_in;
      end
   end

endmodule

[hdl/blt_queue.sv]
// ---------------------------------------------------------------------------
// Basic line tokenizer bundle queue
// Short first-in first-out queue of result bundles between front and back.
// ---------------------------------------------------------------------------
module blt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  blt_pkg::bundle_type     push_bundle,
   input  logic                    pop,
   output blt_pkg::bundle_type     head,
   output blt_pkg::queue_stat_type q_stat
);

   blt_pkg::bundle_type             entry_ff [blt_pkg::QUEUE_DEPTH];
   logic [blt_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [blt_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [blt_pkg::QUEUE_FILL_W-1:0] fill_ff;
   logic                             do_push;
   logic                             do_pop;

   assign q_stat.full  = (fill_ff == blt_pkg::QUEUE_FILL_W'(blt_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (fill_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entry_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

[hdl/blt_back.sv]
// ---------------------------------------------------------------------------
// Basic line tokenizer back end
// Walks the head bundle one result at a time into the output register.
// ---------------------------------------------------------------------------
module blt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  blt_pkg::bundle_type     head,
   input  blt_pkg::queue_stat_type q_stat,
   output logic                    pop,
   blt_rsp_if.source               rsp_link
);

   logic [blt_pkg::SLOT_W-1:0] idx_ff;
   logic                       rsp_valid_ff;
   blt_pkg::result_type        rsp_ff;
   logic                       load;
   logic                       final_slot;

   // The output register takes a new result when empty or being drained.
   assign load       = (!rsp_valid_ff || rsp_link.ready) && !q_stat.empty;
   assign final_slot = ({1'b0, idx_ff} == (head.count - 1'b1));
   assign pop        = load && final_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= final_slot ? '0 : idx_ff + 1'b1;
         end else if (rsp_link.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= head.slot[idx_ff];
      end
   end

   assign rsp_link.valid      = rsp_valid_ff;
   assign rsp_link.kind       = rsp_ff.kind;
   assign rsp_link.text_char  = rsp_ff.text_char;
   assign rsp_link.char_valid = rsp_ff.char_valid;
   assign rsp_link.token_done = rsp_ff.token_done;
   assign rsp_link.error      = rsp_ff.error;
   assign rsp_link.last       = rsp_ff.last;

endmodule

[hdl/basic_line_tokenizer_core.sv]
// ---------------------------------------------------------------------------
// Basic line tokenizer core
// Streaming tokenizer for one source line, one character per input transfer.
// ---------------------------------------------------------------------------
// The block takes one character item per clock while the queue has room, and
// sends one token result per clock while the receiver is ready. An item is
// classified in the cycle it is accepted; its results (zero to four) go into a
// four-entry bundle queue, and the back end presents them from an output
// register, so an item's first result passes through a queue entry and the
// output register. Items with at most one result flow at one per cycle when
// nothing stalls; an item with several results holds the output for each in
// turn, and the queue absorbs such bursts. A line_end item closes the line
// with an End result; after an error result the rest of the line is discarded.
module basic_line_tokenizer_core (
   input  logic      clock,
   input  logic      reset,
   blt_req_if.sink   req_link,
   blt_rsp_if.source rsp_link
);

   blt_pkg::queue_stat_type q_stat;
   blt_pkg::bundle_type     push_bundle;
   blt_pkg::bundle_type     head;
   logic                    push;
   logic                    pop;

   // Character classification and lexer state.
   blt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_link    (req_link),
      .q_stat      (q_stat),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // Decoupling queue.
   blt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .q_stat      (q_stat)
   );

   // Result sequencing.
   blt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_link (rsp_link)
   );

endmodule
